// File: src/cpsp_pkg.sv
`default_nettype none

package cpsp_pkg;

    // Field widths
    localparam int SPEED_W     = 16;
    localparam int POS_W       = 24;
    localparam int GAIN_W      = 16;
    localparam int DUTY_W      = 10;
    localparam int TARGET_W    = 9;
    localparam int ERR_W       = 18;
    localparam int ACC_W       = 32;
    localparam int SUM_W       = 26;
    localparam int TICK_W      = 3;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 24;

    // Fixed limits and reset values
    localparam int SPEED_TARGET_LIMIT    = 200;
    localparam int SPEED_SETPOINT_RESET  = 100;
    localparam int POSITION_TARGET_RESET = 4000;
    localparam int SPEED_OUT_LIMIT_RESET = 1000;

    // Defaults for top level parameters
    localparam int PWM_MAX_DEF      = 1000;
    localparam int OUTER_DIVIDE_DEF = 5;

    // Register map
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_POS_TARGET    = 4'd0,
        REG_SPEED_KP      = 4'd1,
        REG_SPEED_KI      = 4'd2,
        REG_SPEED_KD      = 4'd3,
        REG_SPEED_OUT_LIM = 4'd4,
        REG_POS_KP        = 4'd5,
        REG_POS_KI_T      = 4'd6,
        REG_POS_INT_LIM   = 4'd7
    } cpsp_reg_t;

    typedef struct packed {
        logic signed [POS_W-1:0] position_target;
        logic [GAIN_W-1:0]       speed_kp;
        logic [GAIN_W-1:0]       speed_ki;
        logic [GAIN_W-1:0]       speed_kd;
        logic [GAIN_W-1:0]       speed_out_limit;
        logic [GAIN_W-1:0]       pos_kp;
        logic [GAIN_W-1:0]       pos_ki_t;
        logic [POS_W-1:0]        pos_int_limit;
    } cpsp_cfg_t;

    // Speed loop result for one tick
    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              rev;
    } cpsp_drive_t;

    // Position loop result for one tick
    typedef struct packed {
        logic signed [TARGET_W-1:0] target;
        logic                       updated;
    } cpsp_pos_t;

endpackage

`default_nettype wire

// File: src/cpsp_speed_loop.sv
`default_nettype none

module cpsp_speed_loop #(
    parameter int PWM_MAX = cpsp_pkg::PWM_MAX_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  step,
    input  wire cpsp_pkg::cpsp_cfg_t                   cfg,
    input  wire logic signed [cpsp_pkg::SPEED_W-1:0]   speed_fb,
    input  wire logic signed [cpsp_pkg::TARGET_W-1:0]  setpoint,
    output cpsp_pkg::cpsp_drive_t                      drive
);
    import cpsp_pkg::*;

    localparam int PWM_WHOLE_W = 17;
    localparam logic [PWM_WHOLE_W-1:0] PWM_MAX_W = PWM_WHOLE_W'(PWM_MAX);
    localparam logic [PWM_WHOLE_W-1:0] DUTY_TOP  = PWM_WHOLE_W'((1 << DUTY_W) - 1);
    localparam logic signed [47:0] ACC_MAX = 48'sh0000_7FFF_FFFF;
    localparam logic signed [47:0] ACC_MIN = -48'sh0000_8000_0000;

    logic signed [ERR_W-1:0] err_prev_reg, err_prev_next;
    logic signed [ERR_W-1:0] err_prev2_reg;
    logic signed [ACC_W-1:0] drive_acc_reg, drive_acc_next;

    logic signed [ERR_W-1:0] e0;
    logic signed [19:0]      ep;
    logic signed [19:0]      ed;
    logic signed [16:0]      kp_s, ki_s, kd_s;
    logic signed [36:0]      prod_p, prod_i, prod_d;
    logic signed [38:0]      delta;
    logic signed [47:0]      acc_raw, acc_lim, lim;
    logic [32:0]             mag;
    logic [PWM_WHOLE_W-1:0]  whole, whole_pwm;

    // Error terms of the incremental form
    assign e0   = ERR_W'(setpoint) - ERR_W'(speed_fb);
    assign ep   = 20'(e0) - 20'(err_prev_reg);
    assign ed   = 20'(e0) - (20'(err_prev_reg) <<< 1) + 20'(err_prev2_reg);

    // Gains as positive signed operands
    assign kp_s = signed'({1'b0, cfg.speed_kp});
    assign ki_s = signed'({1'b0, cfg.speed_ki});
    assign kd_s = signed'({1'b0, cfg.speed_kd});

    assign prod_p = kp_s * ep;
    assign prod_i = ki_s * 20'(e0);
    assign prod_d = kd_s * ed;
    assign delta  = 39'(prod_p) + 39'(prod_i) + 39'(prod_d);

    // Accumulate in Q16.16, clamp to the configured limit, then to 32 bits
    assign acc_raw = 48'(drive_acc_reg) + (48'(delta) <<< 8);
    assign lim     = signed'({16'd0, cfg.speed_out_limit, 16'd0});

    always_comb
    begin
        if (acc_raw > lim)
            acc_lim = lim;
        else if (acc_raw < -lim)
            acc_lim = -lim;
        else
            acc_lim = acc_raw;

        if (acc_lim > ACC_MAX)
            drive_acc_next = ACC_W'(ACC_MAX);
        else if (acc_lim < ACC_MIN)
            drive_acc_next = ACC_W'(ACC_MIN);
        else
            drive_acc_next = ACC_W'(acc_lim);
    end

    assign err_prev_next = e0;

    // Magnitude in whole units, bounded by the PWM range and the duty width
    assign mag       = drive_acc_next[ACC_W-1] ? (33'd0 - {1'b1, drive_acc_next})
                                               : {1'b0, drive_acc_next};
    assign whole     = mag[32:16];
    assign whole_pwm = (whole > PWM_MAX_W) ? PWM_MAX_W : whole;

    always_comb
    begin
        drive.duty = (whole_pwm > DUTY_TOP) ? DUTY_W'(DUTY_TOP) : whole_pwm[DUTY_W-1:0];
        drive.rev  = drive_acc_next[ACC_W-1] || (drive_acc_next == '0);
    end

    // Advance the loop state once per tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_prev_reg  <= '0;
            err_prev2_reg <= '0;
            drive_acc_reg <= '0;
        end
        else if (step)
        begin
            err_prev_reg  <= err_prev_next;
            err_prev2_reg <= err_prev_reg;
            drive_acc_reg <= drive_acc_next;
        end
    end

endmodule

`default_nettype wire

// File: src/cpsp_pos_loop.sv
`default_nettype none

module cpsp_pos_loop #(
    parameter int OUTER_DIVIDE = cpsp_pkg::OUTER_DIVIDE_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  step,
    input  wire cpsp_pkg::cpsp_cfg_t                   cfg,
    input  wire logic signed [cpsp_pkg::POS_W-1:0]     position_fb,
    output logic signed [cpsp_pkg::TARGET_W-1:0]       setpoint,
    output cpsp_pkg::cpsp_pos_t                        result
);
    import cpsp_pkg::*;

    localparam logic [TICK_W-1:0]   DIVIDE = TICK_W'(OUTER_DIVIDE);
    localparam logic signed [43:0]  PO_MAX = 44'(SPEED_TARGET_LIMIT * 256);

    logic [TICK_W-1:0]            tick_reg, tick_next, tick_inc;
    logic signed [SUM_W-1:0]      sum_reg, sum_next;
    logic signed [TARGET_W-1:0]   sp_reg, sp_next;
    logic                         run;

    logic signed [POS_W:0]        perr;
    logic signed [SUM_W:0]        sum_raw, ilim, sum_c;
    logic signed [16:0]           kp_s, ki_s;
    logic signed [41:0]           prod_p;
    logic signed [43:0]           prod_i;
    logic signed [43:0]           po;
    logic signed [16:0]           po_c;
    logic signed [TARGET_W-1:0]   q_floor;

    // Tick divider
    assign tick_inc  = tick_reg + TICK_W'(1);
    assign run       = (tick_inc >= DIVIDE);
    assign tick_next = run ? '0 : tick_inc;

    // Position error and clamped error sum
    assign perr    = (POS_W+1)'(cfg.position_target) - (POS_W+1)'(position_fb);
    assign sum_raw = (SUM_W+1)'(sum_reg) + (SUM_W+1)'(perr);
    assign ilim    = signed'({3'd0, cfg.pos_int_limit});

    always_comb
    begin
        if (sum_raw > ilim)
            sum_c = ilim;
        else if (sum_raw < -ilim)
            sum_c = -ilim;
        else
            sum_c = sum_raw;
    end

    assign sum_next = SUM_W'(sum_c);

    // PI output in Q.8, clamped to the speed target range
    assign kp_s   = signed'({1'b0, cfg.pos_kp});
    assign ki_s   = signed'({1'b0, cfg.pos_ki_t});
    assign prod_p = kp_s * perr;
    assign prod_i = ki_s * sum_c;
    assign po     = 44'(prod_p) + prod_i;

    always_comb
    begin
        if (po > PO_MAX)
            po_c = 17'(PO_MAX);
        else if (po < -PO_MAX)
            po_c = 17'(-PO_MAX);
        else
            po_c = 17'(po);
    end

    // Drop the fraction, rounding toward zero
    assign q_floor = TARGET_W'(po_c >>> 8);
    assign sp_next = (po_c[16] && (po_c[7:0] != 8'd0)) ? q_floor + TARGET_W'(1) : q_floor;

    assign setpoint = sp_reg;

    always_comb
    begin
        result.target  = run ? sp_next : sp_reg;
        result.updated = run;
    end

    // Hold the outer state between runs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg <= '0;
            sum_reg  <= '0;
            sp_reg   <= TARGET_W'(SPEED_SETPOINT_RESET);
        end
        else if (step)
        begin
            tick_reg <= tick_next;
            if (run)
            begin
                sum_reg <= sum_next;
                sp_reg  <= sp_next;
            end
        end
    end

endmodule

`default_nettype wire

// File: src/cascaded_position_speed_pid.sv
`default_nettype none

// Cascaded position and speed controller, one control tick per input beat.
// Input channel (in_valid/in_ready) carries speed_feedback and position_feedback.
// Output channel (out_valid/out_ready) returns exactly one beat per tick:
// pwm_duty, reverse_dir, speed_target and outer_updated.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
// gain and limit registers; cfg_ready is always high and an unknown index is
// dropped. Write registers only while no tick is in flight.
// A taken beat lands in the input register, and its result is then captured
// in the result register, which raises out_valid. Throughput is one tick per
// cycle while the receiver keeps up: the speed loop multipliers and the
// position loop multipliers all sit between the input register and the
// result register, and the loop state updates as the result register loads.
// When the receiver stalls, the result register holds and the input register
// keeps one more beat; in_ready drops only when both are full.
// Reset clears the loop state, sets the speed target to 100 and loads the
// register reset values; no output beat is pending after reset.
module cascaded_position_speed_pid #(
    parameter int PWM_MAX      = cpsp_pkg::PWM_MAX_DEF,
    parameter int OUTER_DIVIDE = cpsp_pkg::OUTER_DIVIDE_DEF
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,

    input  wire logic                                    cfg_valid,
    output logic                                         cfg_ready,
    input  wire logic [cpsp_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  wire logic [cpsp_pkg::CFG_DATA_W-1:0]         cfg_data,

    input  wire logic                                    in_valid,
    output logic                                         in_ready,
    input  wire logic signed [cpsp_pkg::SPEED_W-1:0]     speed_feedback,
    input  wire logic signed [cpsp_pkg::POS_W-1:0]       position_feedback,

    output logic                                         out_valid,
    input  wire logic                                    out_ready,
    output logic [cpsp_pkg::DUTY_W-1:0]                  pwm_duty,
    output logic                                         reverse_dir,
    output logic signed [cpsp_pkg::TARGET_W-1:0]         speed_target,
    output logic                                         outer_updated
);
    import cpsp_pkg::*;

    cpsp_cfg_t                  cfg_reg;

    logic                       hold_valid_reg;
    logic signed [SPEED_W-1:0]  fb_reg;
    logic signed [POS_W-1:0]    pos_reg;

    logic                       out_valid_reg;
    cpsp_drive_t                drive_reg;
    cpsp_pos_t                  pos_res_reg;

    logic                       step;
    logic signed [TARGET_W-1:0] setpoint;
    cpsp_drive_t                drive;
    cpsp_pos_t                  pos_res;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.position_target <= POS_W'(POSITION_TARGET_RESET);
            cfg_reg.speed_kp        <= '0;
            cfg_reg.speed_ki        <= '0;
            cfg_reg.speed_kd        <= '0;
            cfg_reg.speed_out_limit <= GAIN_W'(SPEED_OUT_LIMIT_RESET);
            cfg_reg.pos_kp          <= '0;
            cfg_reg.pos_ki_t        <= '0;
            cfg_reg.pos_int_limit   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_POS_TARGET:    cfg_reg.position_target <= signed'(cfg_data[POS_W-1:0]);
                REG_SPEED_KP:      cfg_reg.speed_kp        <= cfg_data[GAIN_W-1:0];
                REG_SPEED_KI:      cfg_reg.speed_ki        <= cfg_data[GAIN_W-1:0];
                REG_SPEED_KD:      cfg_reg.speed_kd        <= cfg_data[GAIN_W-1:0];
                REG_SPEED_OUT_LIM: cfg_reg.speed_out_limit <= cfg_data[GAIN_W-1:0];
                REG_POS_KP:        cfg_reg.pos_kp          <= cfg_data[GAIN_W-1:0];
                REG_POS_KI_T:      cfg_reg.pos_ki_t        <= cfg_data[GAIN_W-1:0];
                REG_POS_INT_LIM:   cfg_reg.pos_int_limit   <= cfg_data[POS_W-1:0];
                default:           ;
            endcase
        end
    end

    // Process the held beat when the result register is free or being drained
    assign step     = hold_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !hold_valid_reg || step;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else if (in_ready)
            hold_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            fb_reg  <= speed_feedback;
            pos_reg <= position_feedback;
        end
    end

    cpsp_speed_loop #(
        .PWM_MAX   (PWM_MAX)
    ) u_speed (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .cfg       (cfg_reg),
        .speed_fb  (fb_reg),
        .setpoint  (setpoint),
        .drive     (drive)
    );

    cpsp_pos_loop #(
        .OUTER_DIVIDE (OUTER_DIVIDE)
    ) u_pos (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .cfg          (cfg_reg),
        .position_fb  (pos_reg),
        .setpoint     (setpoint),
        .result       (pos_res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            drive_reg   <= drive;
            pos_res_reg <= pos_res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pwm_duty      = drive_reg.duty;
    assign reverse_dir   = drive_reg.rev;
    assign speed_target  = pos_res_reg.target;
    assign outer_updated = pos_res_reg.updated;

    // A processed beat always shows up as a pending result
    assert property (@(posedge clk) disable iff (!rst_n) step |=> out_valid_reg)
        else $error("processed tick did not produce a result");

    // A held beat is never dropped without being processed
    assert property (@(posedge clk) disable iff (!rst_n)
        (hold_valid_reg && !step) |=> hold_valid_reg)
        else $error("held input beat lost");

    // Speed target stays within the position loop clamp
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (speed_target <= 9'sd200 && speed_target >= -9'sd200))
        else $error("speed target out of range");

    // Duty never exceeds the PWM maximum
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({7'd0, pwm_duty} <= 17'(PWM_MAX)))
        else $error("duty above PWM maximum");

endmodule

`default_nettype wire

// File: tb/cascaded_position_speed_pid_test.sv
`timescale 1ns / 100ps

module cascaded_position_speed_pid_test;
    import cpsp_pkg::*;

    localparam int PWM_MAX        = PWM_MAX_DEF;
    localparam int OUTER_DIVIDE   = OUTER_DIVIDE_DEF;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int RESET_CYCLES   = 8;
    localparam int TAIL_CYCLES    = 10;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_TICKS    = 150;
    localparam int ZERO_PHASE     = 2;
    localparam int PRESSURE_PHASE = 4;
    localparam int FULL_PHASE     = 5;
    localparam int STALL_AT_TICK  = 20;
    localparam int HOLD_OFF       = 80;
    localparam int IDLE_PERCENT   = 10;

    localparam longint ONE_Q16  = 65536;
    localparam longint ONE_Q8   = 256;
    localparam longint ACC_MAX  = 64'sd2147483647;
    localparam longint ACC_MIN  = -ACC_MAX - 1;
    localparam longint DUTY_CAP = (1 << DUTY_W) - 1;

    localparam logic [CFG_INDEX_W-1:0] UNMAPPED_LO = 4'd8;
    localparam logic [CFG_INDEX_W-1:0] UNMAPPED_HI = 4'd15;

    typedef struct packed {
        logic [DUTY_W-1:0]          duty;
        logic                       rev;
        logic signed [TARGET_W-1:0] target;
        logic                       updated;
    } tick_result_t;

    typedef enum logic { STEP_WRITE, STEP_TICK } step_kind_t;

    typedef struct {
        step_kind_t                kind;
        logic [CFG_INDEX_W-1:0]    index;
        logic [CFG_DATA_W-1:0]     data;
        logic signed [SPEED_W-1:0] speed;
        logic signed [POS_W-1:0]   position;
        bit                        known;
        tick_result_t              want;
    } plan_step_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic signed [SPEED_W-1:0]  speed_feedback = '0;
    logic signed [POS_W-1:0]    position_feedback = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [DUTY_W-1:0]          pwm_duty;
    logic                       reverse_dir;
    logic signed [TARGET_W-1:0] speed_target;
    logic                       outer_updated;

    // Controller copy: registers and loop state
    cpsp_cfg_t    ctrl_regs;
    int           err_last;
    int           err_older;
    int           drive_acc_q;
    int           pos_err_sum;
    int           setpoint;
    int           tick_count;

    tick_result_t pending_results[$];
    plan_step_t   directed_plan[$];
    int           mismatch_count = 0;
    int           cycle_count = 0;
    bit           calm = 1'b0;
    bit           hold_request = 1'b0;

    cascaded_position_speed_pid #(
        .PWM_MAX      (PWM_MAX),
        .OUTER_DIVIDE (OUTER_DIVIDE)
    ) uut (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic longint clamp_range(longint v, longint lo, longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Run one control tick: incremental speed PID, then the position PI when due
    function automatic tick_result_t control_tick(logic signed [SPEED_W-1:0] speed,
                                                  logic signed [POS_W-1:0] position);
        longint       err_now;
        longint       err_step;
        longint       err_bend;
        longint       delta;
        longint       acc;
        longint       drive;
        longint       pos_err;
        longint       sum;
        longint       pos_out;
        tick_result_t r;

        err_now  = longint'(setpoint) - longint'(speed);
        err_step = err_now - longint'(err_last);
        err_bend = err_now - 2 * longint'(err_last) + longint'(err_older);
        delta = longint'(ctrl_regs.speed_kp) * err_step
              + longint'(ctrl_regs.speed_ki) * err_now
              + longint'(ctrl_regs.speed_kd) * err_bend;
        acc = longint'(drive_acc_q) + delta * ONE_Q8;
        acc = clamp_range(acc, -longint'(ctrl_regs.speed_out_limit) * ONE_Q16,
                          longint'(ctrl_regs.speed_out_limit) * ONE_Q16);
        acc = clamp_range(acc, ACC_MIN, ACC_MAX);
        drive_acc_q = int'(acc);
        err_older   = err_last;
        err_last    = int'(err_now);

        // Split the drive into magnitude and direction; zero counts as reverse
        drive = clamp_range(acc, -longint'(PWM_MAX) * ONE_Q16, longint'(PWM_MAX) * ONE_Q16);
        r.rev = (drive <= 0);
        if (drive < 0)
            drive = -drive;
        drive = drive / ONE_Q16;
        r.duty = (drive > DUTY_CAP) ? DUTY_W'(DUTY_CAP) : DUTY_W'(drive);

        // Advance the divider and run the position loop on its wrap
        r.updated  = 1'b0;
        tick_count = (tick_count + 1) % (1 << TICK_W);
        if (tick_count >= OUTER_DIVIDE)
        begin
            tick_count = 0;
            r.updated  = 1'b1;
            pos_err = longint'(ctrl_regs.position_target) - longint'(position);
            sum = clamp_range(longint'(pos_err_sum) + pos_err,
                              -longint'(ctrl_regs.pos_int_limit),
                              longint'(ctrl_regs.pos_int_limit));
            pos_err_sum = int'(sum);
            pos_out = longint'(ctrl_regs.pos_kp) * pos_err
                    + longint'(ctrl_regs.pos_ki_t) * sum;
            pos_out = clamp_range(pos_out, -longint'(SPEED_TARGET_LIMIT) * ONE_Q8,
                                  longint'(SPEED_TARGET_LIMIT) * ONE_Q8);
            setpoint = int'(pos_out / ONE_Q8);
        end
        r.target = TARGET_W'(setpoint);
        return r;
    endfunction

    function automatic void load_register(logic [CFG_INDEX_W-1:0] index,
                                          logic [CFG_DATA_W-1:0] data);
        case (index)
            REG_POS_TARGET:    ctrl_regs.position_target = data[POS_W-1:0];
            REG_SPEED_KP:      ctrl_regs.speed_kp        = data[GAIN_W-1:0];
            REG_SPEED_KI:      ctrl_regs.speed_ki        = data[GAIN_W-1:0];
            REG_SPEED_KD:      ctrl_regs.speed_kd        = data[GAIN_W-1:0];
            REG_SPEED_OUT_LIM: ctrl_regs.speed_out_limit = data[GAIN_W-1:0];
            REG_POS_KP:        ctrl_regs.pos_kp          = data[GAIN_W-1:0];
            REG_POS_KI_T:      ctrl_regs.pos_ki_t        = data[GAIN_W-1:0];
            REG_POS_INT_LIM:   ctrl_regs.pos_int_limit   = data[POS_W-1:0];
            default:           ;
        endcase
    endfunction

    function automatic tick_result_t outcome(int duty, bit rev, int target, bit updated);
        tick_result_t r;
        r.duty    = DUTY_W'(duty);
        r.rev     = rev;
        r.target  = TARGET_W'(target);
        r.updated = updated;
        return r;
    endfunction

    function automatic void plan_write(logic [CFG_INDEX_W-1:0] index,
                                       logic [CFG_DATA_W-1:0] data);
        plan_step_t s;
        s.kind  = STEP_WRITE;
        s.index = index;
        s.data  = data;
        s.known = 1'b0;
        directed_plan.push_back(s);
    endfunction

    function automatic void plan_tick(logic signed [SPEED_W-1:0] speed,
                                      logic signed [POS_W-1:0] position,
                                      bit known = 1'b0, tick_result_t want = '0);
        plan_step_t s;
        s.kind     = STEP_TICK;
        s.speed    = speed;
        s.position = position;
        s.known    = known;
        s.want     = want;
        directed_plan.push_back(s);
    endfunction

    // Mostly near the current setpoint so the speed loop stays in its linear range
    function automatic logic signed [SPEED_W-1:0] pick_speed();
        case ($urandom_range(0, 9))
            0:       return SPEED_W'($urandom);
            1:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: return SPEED_W'(setpoint + int'($urandom_range(0, 64)) - 32);
        endcase
    endfunction

    function automatic logic signed [POS_W-1:0] pick_position();
        case ($urandom_range(0, 9))
            0:       return POS_W'($urandom);
            1:       return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
            default: return POS_W'(int'(ctrl_regs.position_target)
                                   + int'($urandom_range(0, 4000)) - 2000);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_setting(int width, int unsigned typical);
        logic [31:0] mask;
        mask = (32'd1 << width) - 32'd1;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return CFG_DATA_W'(mask);
            2, 3:    return CFG_DATA_W'($urandom & mask);
            default: return CFG_DATA_W'($urandom_range(0, typical));
        endcase
    endfunction

    // Drop both channels and wait for every outstanding result beat
    task automatic settle();
        @(negedge clk);
        in_valid  <= 1'b0;
        cfg_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_INDEX_W-1:0] index,
                                  logic [CFG_DATA_W-1:0] data);
        settle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        load_register(index, data);
    endtask

    // Offer one tick beat; predict its result once the beat is taken
    task automatic send_tick(logic signed [SPEED_W-1:0] speed,
                             logic signed [POS_W-1:0] position,
                             bit known, tick_result_t want);
        tick_result_t predicted;
        @(negedge clk);
        cfg_valid <= 1'b0;
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid          <= 1'b1;
        speed_feedback    <= speed;
        position_feedback <= position;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = control_tick(speed, position);
        pending_results.push_back(known ? want : predicted);
    endtask

    task automatic compare_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Result side: random idling, plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_OFF;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Match each result beat against the oldest prediction
    always @(posedge clk)
    begin
        tick_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result beat with no tick pending: expected none, got %0d %0b %0d %0b",
                         $time, pwm_duty, reverse_dir, speed_target, outer_updated);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("pwm_duty", want.duty, pwm_duty);
                compare_field("reverse_dir", want.rev, reverse_dir);
                compare_field("speed_target", want.target, speed_target);
                compare_field("outer_updated", want.updated, outer_updated);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int                    width;
        int unsigned           typical;
        logic [CFG_DATA_W-1:0] value;

        // Hold the controller copy at its reset values
        ctrl_regs                 = '0;
        ctrl_regs.position_target = POSITION_TARGET_RESET;
        ctrl_regs.speed_out_limit = SPEED_OUT_LIMIT_RESET;
        err_last    = 0;
        err_older   = 0;
        drive_acc_q = 0;
        pos_err_sum = 0;
        setpoint    = SPEED_SETPOINT_RESET;
        tick_count  = 0;

        // Reset values: zero gains keep the drive at zero; the first position update drops the target to 0
        plan_tick(16'sh7FFF, 24'sh7FFFFF, 1'b1, outcome(0, 1'b1, 100, 1'b0));
        plan_tick(16'sh8000, 24'sh800000, 1'b1, outcome(0, 1'b1, 100, 1'b0));
        plan_tick(16'sh0000, 24'sh000000, 1'b1, outcome(0, 1'b1, 100, 1'b0));
        plan_tick(16'sh0001, 24'shFFFFFF, 1'b1, outcome(0, 1'b1, 100, 1'b0));
        plan_tick(16'shFFFF, 24'sh000001, 1'b1, outcome(0, 1'b1, 0, 1'b1));

        // Full-scale gains and limits; unmapped indexes must be dropped
        plan_write(REG_SPEED_KP, 24'h00FFFF);
        plan_write(REG_SPEED_KI, 24'h00FFFF);
        plan_write(REG_SPEED_KD, 24'h00FFFF);
        plan_write(REG_SPEED_OUT_LIM, 24'h00FFFF);
        plan_write(REG_POS_KP, 24'h00FFFF);
        plan_write(REG_POS_KI_T, 24'h00FFFF);
        plan_write(REG_POS_INT_LIM, 24'hFFFFFF);
        plan_write(REG_POS_TARGET, 24'h7FFFFF);
        plan_write(UNMAPPED_LO, 24'hFFFFFF);
        plan_write(UNMAPPED_HI, 24'hFFFFFF);
        plan_tick(16'sh7FFF, 24'sh800000);
        plan_tick(16'sh8000, 24'sh800000);
        plan_tick(16'sh7FFF, 24'sh800000);
        plan_tick(16'sh8000, 24'sh800000);
        plan_tick(16'sh0000, 24'sh800000);

        // Zero drive limit pins the drive; the position loop swings to the negative clamp
        plan_write(REG_POS_TARGET, 24'h800000);
        plan_write(REG_SPEED_OUT_LIM, 24'h000000);
        plan_tick(16'sh7FFF, 24'sh7FFFFF, 1'b1, outcome(0, 1'b1, 200, 1'b0));
        plan_tick(16'sh8000, 24'sh7FFFFF, 1'b1, outcome(0, 1'b1, 200, 1'b0));
        plan_tick(16'sh5555, 24'sh7FFFFF, 1'b1, outcome(0, 1'b1, 200, 1'b0));
        plan_tick(16'shAAAA, 24'sh7FFFFF, 1'b1, outcome(0, 1'b1, 200, 1'b0));
        plan_tick(16'sh0000, 24'sh7FFFFF, 1'b1, outcome(0, 1'b1, -200, 1'b1));

        // Tiny integral gain: a drive just above zero reads as duty 0, forward
        plan_write(REG_SPEED_KP, 24'h000000);
        plan_write(REG_SPEED_KD, 24'h000000);
        plan_write(REG_SPEED_KI, 24'h000001);
        plan_write(REG_SPEED_OUT_LIM, 24'd1000);
        plan_write(REG_POS_KP, 24'h000000);
        plan_write(REG_POS_KI_T, 24'h000000);
        plan_write(REG_POS_INT_LIM, 24'h000000);
        plan_write(REG_POS_TARGET, 24'h000000);
        plan_tick(-16'sd200, 24'sh000000, 1'b1, outcome(0, 1'b1, -200, 1'b0));
        plan_tick(-16'sd201, 24'sh000000, 1'b1, outcome(0, 1'b0, -200, 1'b0));
        plan_tick(-16'sd200, 24'sh123456);
        plan_tick(16'sh5555, 24'shAAAAAA);
        plan_tick(16'shAAAA, 24'sh555555);

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        foreach (directed_plan[i])
        begin
            if (directed_plan[i].kind == STEP_WRITE)
                write_register(directed_plan[i].index, directed_plan[i].data);
            else
                send_tick(directed_plan[i].speed, directed_plan[i].position,
                          directed_plan[i].known, directed_plan[i].want);
        end

        // Random phases, each with a fresh register setting
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            calm = 1'b0;
            for (int r = REG_POS_TARGET; r <= REG_POS_INT_LIM; r++)
            begin
                width = (r == REG_POS_TARGET || r == REG_POS_INT_LIM) ? POS_W : GAIN_W;
                case (r)
                    REG_POS_TARGET:    typical = 20000;
                    REG_SPEED_OUT_LIM: typical = 1500;
                    REG_POS_KP:        typical = 512;
                    REG_POS_INT_LIM:   typical = 50000;
                    default:           typical = 64;
                endcase
                value = pick_setting(width, typical);
                if (phase == ZERO_PHASE)
                    value = '0;
                else if (phase == FULL_PHASE)
                    value = CFG_DATA_W'((32'd1 << width) - 32'd1);
                write_register(CFG_INDEX_W'(r), value);
            end
            write_register(CFG_INDEX_W'($urandom_range(UNMAPPED_LO, UNMAPPED_HI)),
                           CFG_DATA_W'($urandom));

            // Keep one phase free of idling, with a long result stall inside it
            calm = (phase == PRESSURE_PHASE);
            for (int n = 0; n < PHASE_TICKS; n++)
            begin
                if (phase == PRESSURE_PHASE && n == STALL_AT_TICK)
                    hold_request = 1'b1;
                send_tick(pick_speed(), pick_position(), 1'b0, '0);
            end
        end

        calm = 1'b0;
        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
